### hw/rtl/hiv_pkg.sv
// Shared types, constants and character classes for the endpoint name checker.
// No dependencies; every other file of the block imports this package.
package hiv_pkg;

    // Default length bounds
    localparam int unsigned DEF_MAX_NAME_LENGTH  = 253;
    localparam int unsigned DEF_MAX_LABEL_LENGTH = 63;

    // Character codes and limits
    localparam logic [7:0] DOT_CHAR        = 8'h2E;
    localparam logic [7:0] HYPHEN_CHAR     = 8'h2D;
    localparam logic [7:0] ZERO_CHAR       = 8'h30;
    localparam logic [2:0] QUAD_LABELS     = 3'd4;
    localparam logic [2:0] LABEL_COUNT_MAX = 3'd7;
    localparam logic [8:0] OCTET_MAX       = 9'd255;

    // Running state of the string being checked
    typedef struct packed {
        logic [7:0] total_length;
        logic [6:0] label_length;
        logic [7:0] previous_symbol;
        logic [2:0] label_count;
        logic [8:0] octet_value;
        logic       all_digits;
        logic       octet_overflow;
        logic       failed;
    } hiv_state_t;

    // Verdict for one complete string
    typedef struct packed {
        logic dotted_numeric;
        logic valid_res;
    } hiv_verdict_t;

    localparam hiv_state_t STATE_RESET = '{
        total_length:    8'd0,
        label_length:    7'd0,
        previous_symbol: DOT_CHAR,
        label_count:     3'd0,
        octet_value:     9'd0,
        all_digits:      1'b1,
        octet_overflow:  1'b0,
        failed:          1'b0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

### hw/rtl/hiv_step.sv
// Next-state and verdict logic for one character of the endpoint string.
// Depends on hiv_pkg for the state and verdict types and character classes.
module hiv_step #(
    parameter int unsigned MAX_NAME_LENGTH  = hiv_pkg::DEF_MAX_NAME_LENGTH,
    parameter int unsigned MAX_LABEL_LENGTH = hiv_pkg::DEF_MAX_LABEL_LENGTH
) (
    input  hiv_pkg::hiv_state_t   cur,
    input  logic [7:0]            symbol,
    output hiv_pkg::hiv_state_t   nxt,
    output hiv_pkg::hiv_verdict_t verdict
);
    import hiv_pkg::*;

    logic        sym_alnum;
    logic        sym_digit;
    logic        sym_dot;
    logic [11:0] oct_wide;
    logic [11:0] oct_sum;
    logic        ok;

    assign sym_alnum = is_alnum(symbol);
    assign sym_digit = is_digit(symbol);
    assign sym_dot   = (symbol == DOT_CHAR);

    // Decimal accumulate: value * 10 + digit
    assign oct_wide = {3'd0, cur.octet_value};
    assign oct_sum  = (oct_wide << 3) + (oct_wide << 1) + {4'd0, symbol - ZERO_CHAR};

    // Advance counters and flags
    always_comb
    begin
        nxt = cur;
        nxt.previous_symbol = symbol;

        if (cur.total_length >= 8'(MAX_NAME_LENGTH))
            nxt.failed = 1'b1;
        else
            nxt.total_length = cur.total_length + 8'd1;

        if (sym_dot)
        begin
            if ((cur.label_length == 7'd0) || !is_alnum(cur.previous_symbol))
                nxt.failed = 1'b1;
            if (cur.label_count < LABEL_COUNT_MAX)
                nxt.label_count = cur.label_count + 3'd1;
            nxt.label_length = 7'd0;
            nxt.octet_value  = 9'd0;
        end
        else
        begin
            if ((cur.label_length == 7'd0) && !sym_alnum)
                nxt.failed = 1'b1;
            if (!sym_alnum && (symbol != HYPHEN_CHAR))
                nxt.failed = 1'b1;
            if (cur.label_length >= 7'(MAX_LABEL_LENGTH))
                nxt.failed = 1'b1;
            else
                nxt.label_length = cur.label_length + 7'd1;
            if (sym_digit)
            begin
                if (oct_sum > {3'd0, OCTET_MAX})
                begin
                    nxt.octet_overflow = 1'b1;
                    nxt.octet_value    = OCTET_MAX + 9'd1;
                end
                else
                begin
                    nxt.octet_value = oct_sum[8:0];
                end
            end
            else
            begin
                nxt.all_digits = 1'b0;
            end
        end
    end

    // Form the verdict as if this character closes the string
    always_comb
    begin
        ok = !nxt.failed && !sym_dot && sym_alnum;
        if (ok && nxt.all_digits &&
            ((nxt.label_count != QUAD_LABELS - 3'd1) || nxt.octet_overflow))
            ok = 1'b0;
        verdict.valid_res      = ok;
        verdict.dotted_numeric = nxt.all_digits;
    end

endmodule

### hw/rtl/hiv_out.sv
// Output register stage holding one verdict until the downstream side takes it.
// Depends on hiv_pkg for the verdict type.
module hiv_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  hiv_pkg::hiv_verdict_t verdict,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata     // [0] valid_res, [1] dotted_numeric
);
    import hiv_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    hiv_verdict_t data_reg;

    // Slot is free when empty or draining this cycle
    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture a new verdict
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= verdict;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, data_reg.dotted_numeric, data_reg.valid_res};

endmodule

### hw/rtl/hostname_ipv4_validator_unit.sv
// Top level of the endpoint name checker (host name or dotted-quad address).
// Depends on hiv_pkg, hiv_step and hiv_out.
//
//  channel  dir  signals                       beat carries
//  s_       in   s_tvalid s_tready s_tdata     one character, s_tlast on the final one
//  m_       out  m_tvalid m_tready m_tdata     one verdict per string
//
// One character per cycle while the input is not stalled; the verdict appears in the cycle after the final beat.
// The per-character state register and the output register are the only stages.
// Reset returns the string state to empty and drops any pending verdict.
// Input stalls only while a verdict waits in the output register untaken.
module hostname_ipv4_validator_unit #(
    parameter int unsigned MAX_NAME_LENGTH  = hiv_pkg::DEF_MAX_NAME_LENGTH,
    parameter int unsigned MAX_LABEL_LENGTH = hiv_pkg::DEF_MAX_LABEL_LENGTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] symbol
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // [0] valid_res, [1] dotted_numeric, [7:2] zero
);
    import hiv_pkg::*;

    hiv_state_t   state_reg;
    hiv_state_t   state_next;
    hiv_state_t   step_state;
    hiv_verdict_t step_verdict;
    logic         out_free;
    logic         accept;

    assign s_tready = out_free;
    assign accept   = s_tvalid && s_tready;

    hiv_step #(
        .MAX_NAME_LENGTH  (MAX_NAME_LENGTH),
        .MAX_LABEL_LENGTH (MAX_LABEL_LENGTH)
    ) u_step (
        .cur     (state_reg),
        .symbol  (s_tdata),
        .nxt     (step_state),
        .verdict (step_verdict)
    );

    // Advance on each beat; start over after the final character
    always_comb
    begin
        state_next = state_reg;
        if (accept)
            state_next = s_tlast ? STATE_RESET : step_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else
            state_reg <= state_next;
    end

    hiv_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && s_tlast),
        .verdict  (step_verdict),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A final beat always yields a verdict on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> m_tvalid)
        else $error("verdict missing after final character");

    // State is back to empty after a final beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (state_reg == STATE_RESET))
        else $error("string state not cleared after verdict");

    // Length counters never pass their bounds
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.total_length <= 8'(MAX_NAME_LENGTH)) &&
        (state_reg.label_length <= 7'(MAX_LABEL_LENGTH)))
        else $error("length counter beyond bound");

    // A plain character beat leaves no new verdict behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tlast && !m_tvalid) |=> !m_tvalid)
        else $error("verdict produced without final character");

endmodule

### bench/hostname_ipv4_validator_unit_tb.sv
// Self-checking bench for the endpoint name checker: streams host names, dotted quads,
// noise and damaged strings, and checks every verdict against a cycle-free predictor.
// Depends on hiv_pkg and hostname_ipv4_validator_unit.
module hostname_ipv4_validator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hiv_pkg::*;

    typedef logic [7:0] char_t;

    localparam int NAME_LIMIT  = DEF_MAX_NAME_LENGTH;
    localparam int LABEL_LIMIT = DEF_MAX_LABEL_LENGTH;
    localparam int CHAR_BUDGET = 1550;
    localparam int IDLE_PCT    = 18;
    localparam int HOLD_CYCLES = 250;
    localparam int CYCLE_LIMIT = 200000;

    // Predict one verdict per string and match verdicts in arrival order
    class endpoint_scoreboard;
        logic [7:0] name_len;
        logic [6:0] label_len;
        char_t      prev_char;
        logic [2:0] labels_closed;
        logic [8:0] octet;
        bit         digits_only;
        bit         octet_big;
        bit         broken;
        logic [7:0] verdict_q[$];
        int         errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            name_len      = '0;
            label_len     = '0;
            prev_char     = DOT_CHAR;
            labels_closed = '0;
            octet         = '0;
            digits_only   = 1'b1;
            octet_big     = 1'b0;
            broken        = 1'b0;
        endfunction

        function bit char_digit(char_t c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function bit char_alnum(char_t c);
            return char_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        // Advance the string state by one accepted character beat
        function void note_char(char_t c, logic fin);
            int v;
            bit ok;
            if (name_len >= NAME_LIMIT)
                broken = 1'b1;
            else
                name_len++;

            if (c == DOT_CHAR)
            begin
                if (label_len == 0 || !char_alnum(prev_char))
                    broken = 1'b1;
                if (labels_closed < LABEL_COUNT_MAX)
                    labels_closed++;
                label_len = '0;
                octet     = '0;
            end
            else
            begin
                if (label_len == 0 && !char_alnum(c))
                    broken = 1'b1;
                if (!char_alnum(c) && c != HYPHEN_CHAR)
                    broken = 1'b1;
                if (label_len >= LABEL_LIMIT)
                    broken = 1'b1;
                else
                    label_len++;
                if (char_digit(c))
                begin
                    v = int'(octet) * 10 + int'(c - ZERO_CHAR);
                    // saturate just above the largest octet
                    if (v > int'(OCTET_MAX))
                    begin
                        octet_big = 1'b1;
                        v = int'(OCTET_MAX) + 1;
                    end
                    octet = v[8:0];
                end
                else
                    digits_only = 1'b0;
            end
            prev_char = c;

            if (fin)
            begin
                ok = !broken && c != DOT_CHAR && char_alnum(c);
                // an all-numeric string must be a proper dotted quad
                if (ok && digits_only &&
                    (int'(labels_closed) + 1 != int'(QUAD_LABELS) || octet_big))
                    ok = 1'b0;
                verdict_q.insert(verdict_q.size(), {6'b0, digits_only, ok});
                clear();
            end
        endfunction

        // Compare one verdict beat with the oldest prediction
        function void check_verdict(logic [7:0] got);
            logic [7:0] exp_v;
            bit bad;
            if (verdict_q.size() == 0)
            begin
                errors++;
                $display("%0t: verdict with none pending, expected none, got %02h", $time, got);
                return;
            end
            exp_v = verdict_q.pop_front();
            bad = 1'b0;
            if (got[0] !== exp_v[0])
            begin
                bad = 1'b1;
                $display("%0t: valid_res mismatch, expected %0b, got %0b", $time, exp_v[0], got[0]);
            end
            if (got[1] !== exp_v[1])
            begin
                bad = 1'b1;
                $display("%0t: dotted_numeric mismatch, expected %0b, got %0b",
                         $time, exp_v[1], got[1]);
            end
            if (got[7:2] !== exp_v[7:2])
            begin
                bad = 1'b1;
                $display("%0t: pad bits mismatch, expected %02h, got %02h",
                         $time, exp_v[7:2], got[7:2]);
            end
            if (bad)
                errors++;
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;     // [7:0] symbol
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;             // [0] valid_res, [1] dotted_numeric, [7:2] zero

    endpoint_scoreboard verdicts = new();
    bit hold_req = 1'b0;
    bit calm = 1'b0;
    int chars_sent = 0;
    int string_count = 0;
    int cycle_count = 0;
    char_t text[$];

    hostname_ipv4_validator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Take verdict beats; stall at random or for a long hold when asked
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                verdicts.check_verdict(m_tdata);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Offer one character beat and hold it until taken
    task automatic send_char(input char_t c, input logic fin);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        verdicts.note_char(c, fin);
        chars_sent++;
    endtask

    task automatic send_text(input char_t s[$]);
        for (int i = 0; i < s.size(); i++)
            send_char(s[i], i == s.size() - 1);
    endtask

    task automatic send_str(input string txt);
        char_t q[$];
        for (int i = 0; i < txt.len(); i++)
            q.insert(q.size(), txt[i]);
        send_text(q);
    endtask

    // Drop valid and hold until every verdict is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (verdicts.pending() > 0)
            @(posedge clk);
    endtask

    function automatic char_t pick_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return char_t'(8'h30 + r);
        else if (r < 36)
            return char_t'(8'h41 + r - 10);
        return char_t'(8'h61 + r - 36);
    endfunction

    function automatic char_t pick_ldh();
        if ($urandom_range(0, 5) == 0)
            return HYPHEN_CHAR;
        return pick_alnum();
    endfunction

    // Append a label with letter-or-digit ends and hyphens inside
    function automatic void add_name_label(ref char_t s[$], input int len);
        for (int i = 0; i < len; i++)
            s.insert(s.size(), (i == 0 || i == len - 1) ? pick_alnum() : pick_ldh());
    endfunction

    // Append a decimal label: mostly a real octet, sometimes a loose digit run
    function automatic void add_number_label(ref char_t s[$]);
        string txt;
        int zeros;
        if ($urandom_range(0, 99) < 70)
        begin
            txt = $sformatf("%0d", $urandom_range(0, 255));
            zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (zeros)
                s.insert(s.size(), ZERO_CHAR);
            for (int i = 0; i < txt.len(); i++)
                s.insert(s.size(), txt[i]);
        end
        else
            repeat ($urandom_range(1, 5))
                s.insert(s.size(), char_t'(ZERO_CHAR + $urandom_range(0, 9)));
    endfunction

    function automatic void make_host(ref char_t s[$]);
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                s.insert(s.size(), DOT_CHAR);
            add_name_label(s, ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66)
                                                            : $urandom_range(1, 8));
        end
    endfunction

    function automatic void make_quad(ref char_t s[$]);
        int n;
        n = ($urandom_range(0, 9) < 7) ? 4 : $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                s.insert(s.size(), DOT_CHAR);
            add_number_label(s);
        end
    endfunction

    // Build a well-formed name of an exact total length from full-size labels
    function automatic void make_long(ref char_t s[$], input int total);
        int rem;
        int len;
        rem = total;
        while (rem > 0)
        begin
            len = (rem > LABEL_LIMIT) ? LABEL_LIMIT : rem;
            if (rem - len == 1)
                len--;
            add_name_label(s, len);
            rem -= len;
            if (rem > 0)
            begin
                s.insert(s.size(), DOT_CHAR);
                rem--;
            end
        end
    endfunction

    function automatic void make_noise(ref char_t s[$]);
        repeat ($urandom_range(1, 10))
            s.insert(s.size(), char_t'($urandom_range(0, 255)));
    endfunction

    // Damage an otherwise good string in one place
    function automatic void break_text(ref char_t s[$]);
        int pos;
        pos = $urandom_range(0, s.size() - 1);
        case ($urandom_range(0, 4))
            0: s[pos] = char_t'($urandom_range(0, 255));
            1: s.insert(pos, DOT_CHAR);
            2: s.insert(s.size(), DOT_CHAR);
            3: s.push_front(HYPHEN_CHAR);
            default: s[s.size() - 1] = HYPHEN_CHAR;
        endcase
    endfunction

    // Main stimulus
    initial
    begin
        int mode;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings: byte extremes, quad rules, bad first characters
        send_str("1.2.3.4");
        send_str("a-Z");
        send_str(".");
        send_str("-");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        send_str("256.1.1.1");
        send_str("1.2.3");
        wait_drained();

        // random strings
        while (chars_sent < CHAR_BUDGET)
        begin
            text.delete();
            mode = $urandom_range(0, 99);
            if (string_count == 20)
                make_long(text, NAME_LIMIT);
            else if (string_count == 60)
                make_long(text, NAME_LIMIT + 1);
            else if (mode < 30)
                make_host(text);
            else if (mode < 55)
                make_quad(text);
            else if (mode < 67)
                make_noise(text);
            else
            begin
                if (mode < 84)
                    make_host(text);
                else
                    make_quad(text);
                break_text(text);
            end

            if (string_count == 40)
                hold_req = 1'b1;
            calm = string_count >= 80 && string_count < 110;
            if (string_count == 120)
                wait_drained();
            send_text(text);
            string_count++;
        end

        // drain and settle
        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (verdicts.pending() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (verdicts.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
